/* rtl/rgb_image_difference_stats_top_macros.svh */
// Assertion macros for the image difference statistics checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RGB_IMAGE_DIFFERENCE_STATS_TOP_MACROS_SVH
`define RGB_IMAGE_DIFFERENCE_STATS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RIDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rids_pkg.sv */
// Shared types and constants for the image difference statistics block.
// No dependencies; every other source file but the macro header imports this package.
`timescale 1ns / 1ps

package rids_pkg;

	localparam int CHANNELS   = 3;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 13;
	localparam int THR_W      = 9;
	localparam int SUM_W      = 34;
	localparam int CNT_W      = 25;
	localparam int PSUM_W     = 10;
	localparam int MEAN_W     = 16;
	localparam int FRAC_W     = 17;
	localparam int MEAN_SHIFT = 8;
	localparam int FRAC_SHIFT = 16;

	// serial divider operand widths
	localparam int NUM_W  = SUM_W + MEAN_SHIFT + 2;
	localparam int DEN_W  = CNT_W + 3;
	localparam int QCNT_W = $clog2(NUM_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [MEAN_W-1:0] MEAN_CAP = MEAN_W'(65280);
	localparam logic [FRAC_W-1:0] FRAC_CAP = FRAC_W'(65536);
	localparam logic [PIX_W-1:0]  MAX_CAP  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_A    = 3'd0,
		REG_HEIGHT_A   = 3'd1,
		REG_WIDTH_B    = 3'd2,
		REG_HEIGHT_B   = 3'd3,
		REG_THRESHOLD  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] over;
		logic [PIX_W-1:0] max;
		logic [CNT_W-1:0] n;
	} acc_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

/* rtl/rids_if.sv */
// Stream interfaces: pixel pair channel and result channel.
// Depends on rids_pkg for field widths.
`timescale 1ns / 1ps

interface rids_pix_if;
	import rids_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] a_red;
	logic [PIX_W-1:0] a_green;
	logic [PIX_W-1:0] a_blue;
	logic [PIX_W-1:0] b_red;
	logic [PIX_W-1:0] b_green;
	logic [PIX_W-1:0] b_blue;
	logic             last_pixel;

	modport source (output valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
		last_pixel, input ready);
	modport sink (input valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
		last_pixel, output ready);
endinterface

interface rids_res_if;
	import rids_pkg::*;
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] mean_diff_fx;
	logic [FRAC_W-1:0] fraction_over_fx;
	logic [PIX_W-1:0]  max_diff;
	logic [SUM_W-1:0]  diff_total;
	logic [CNT_W-1:0]  pixels_over;
	logic              size_mismatch;

	modport source (output valid, mean_diff_fx, fraction_over_fx, max_diff, diff_total,
		pixels_over, size_mismatch, input ready);
	modport sink (input valid, mean_diff_fx, fraction_over_fx, max_diff, diff_total,
		pixels_over, size_mismatch, output ready);
endinterface

/* rtl/rgb_image_difference_stats_top.sv */
// Channel  | Dir | Carries
// pix      | in  | one pixel pair per beat: a_/b_ red, green, blue, last_pixel
// res      | out | one statistics beat per image comparison
// cfg_*    | in  | register writes: sizes of both images, over threshold
//
// Pixel beats are taken one per clock while accumulating (three lanes + merge).
// After the last beat the shared serial divider runs twice (mean, then fraction), unless
// the sizes differ or are zero; ST_EMIT then loads the output register.
// pix.ready is low from the last beat until the result is loaded; the next image
// may stream while the previous result waits on res.ready.
// Reset (arst_n low) clears config, accumulators, divider control and the result valid.
`timescale 1ns / 1ps

module rgb_image_difference_stats_top import rids_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rids_pix_if.sink              pix,
	rids_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_FRAC_GO,
		ST_FRAC_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]        width_a_q;
	logic [DIM_W-1:0]        height_a_q;
	logic [DIM_W-1:0]        width_b_q;
	logic [DIM_W-1:0]        height_b_q;
	logic signed [THR_W-1:0] thr_q;

	logic             pix_acc;
	logic             valid_s1;
	logic             last_s1;
	logic [PIX_W-1:0] a_arr    [CHANNELS];
	logic [PIX_W-1:0] b_arr    [CHANNELS];
	logic [PIX_W-1:0] diff_s1  [CHANNELS];
	acc_t             total;

	logic              mismatch;
	logic              empty;
	logic [SUM_W-1:0]  rsum_q;
	logic [CNT_W-1:0]  rover_q;
	logic [PIX_W-1:0]  rmax_q;
	logic [CNT_W-1:0]  n_q;
	logic              mis_q;
	logic [MEAN_W-1:0] mean_q;
	logic [FRAC_W-1:0] frac_q;

	logic              out_valid_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic [FRAC_W-1:0] out_frac_q;
	logic [PIX_W-1:0]  out_max_q;
	logic [SUM_W-1:0]  out_sum_q;
	logic [CNT_W-1:0]  out_over_q;
	logic              out_mis_q;
	logic              emit_load;

	logic [NUM_W-1:0] n_ext;
	logic [NUM_W-1:0] mean_num;
	logic [NUM_W-1:0] frac_num;
	logic [DEN_W-1:0] mean_den;
	logic [DEN_W-1:0] frac_den;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_a_q  <= '0;
			height_a_q <= '0;
			width_b_q  <= '0;
			height_b_q <= '0;
			thr_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_A:   width_a_q  <= cfg_data;
				REG_HEIGHT_A:  height_a_q <= cfg_data;
				REG_WIDTH_B:   width_b_q  <= cfg_data;
				REG_HEIGHT_B:  height_b_q <= cfg_data;
				REG_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix.ready = (state_q == ST_ACCUM) && !(valid_s1 && last_s1);
	assign pix_acc   = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= pix_acc;
			if (pix_acc) begin
				last_s1 <= pix.last_pixel;
			end
		end
	end

	assign a_arr = '{pix.a_red, pix.a_green, pix.a_blue};
	assign b_arr = '{pix.b_red, pix.b_green, pix.b_blue};

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		rids_lane u_lane (
			.clk     (clk),
			.en      (pix_acc),
			.a       (a_arr[c]),
			.b       (b_arr[c]),
			.diff_s1 (diff_s1[c])
		);
	end

	rids_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.last_s1  (last_s1),
		.diff_s1  (diff_s1),
		.thr      (thr_q),
		.total    (total)
	);

	assign mismatch = (width_a_q != width_b_q) || (height_a_q != height_b_q);
	assign empty    = (width_a_q == '0) || (height_a_q == '0);

	// mean = (2*sum*256 + 3n) / 6n, frac = (2*over*65536 + n) / 2n
	assign n_ext    = NUM_W'(n_q);
	assign mean_num = (NUM_W'(rsum_q) << (MEAN_SHIFT + 1)) + (n_ext << 1) + n_ext;
	assign frac_num = (NUM_W'(rover_q) << (FRAC_SHIFT + 1)) + n_ext;
	assign mean_den = (DEN_W'(n_q) << 2) + (DEN_W'(n_q) << 1);
	assign frac_den = DEN_W'(n_q) << 1;

	always_comb begin
		div_req.start = (state_q == ST_MEAN_GO) || (state_q == ST_FRAC_GO);
		div_req.num   = (state_q == ST_FRAC_GO) ? frac_num : mean_num;
		div_req.den   = (state_q == ST_FRAC_GO) ? frac_den : mean_den;
	end

	rids_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register free, or its beat leaves this cycle
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
			rsum_q      <= '0;
			rover_q     <= '0;
			rmax_q      <= '0;
			n_q         <= '0;
			mis_q       <= 1'b0;
			mean_q      <= '0;
			frac_q      <= '0;
			out_mean_q  <= '0;
			out_frac_q  <= '0;
			out_max_q   <= '0;
			out_sum_q   <= '0;
			out_over_q  <= '0;
			out_mis_q   <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACCUM: begin
					if (valid_s1 && last_s1) begin
						mis_q <= mismatch;
						n_q   <= total.n;
						if (mismatch) begin
							mean_q  <= MEAN_CAP;
							frac_q  <= FRAC_CAP;
							rmax_q  <= MAX_CAP;
							rsum_q  <= '0;
							rover_q <= '0;
							state_q <= ST_EMIT;
						end else if (empty) begin
							mean_q  <= '0;
							frac_q  <= '0;
							rmax_q  <= '0;
							rsum_q  <= '0;
							rover_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							rmax_q  <= total.max;
							rsum_q  <= total.sum;
							rover_q <= total.over;
							state_q <= ST_MEAN_GO;
						end
					end
				end
				ST_MEAN_GO: state_q <= ST_MEAN_WAIT;
				ST_MEAN_WAIT: begin
					if (div_rsp.done) begin
						mean_q  <= (div_rsp.quot > NUM_W'(MEAN_CAP)) ? MEAN_CAP
							: div_rsp.quot[MEAN_W-1:0];
						state_q <= ST_FRAC_GO;
					end
				end
				ST_FRAC_GO: state_q <= ST_FRAC_WAIT;
				ST_FRAC_WAIT: begin
					if (div_rsp.done) begin
						frac_q  <= (div_rsp.quot > NUM_W'(FRAC_CAP)) ? FRAC_CAP
							: div_rsp.quot[FRAC_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_mean_q  <= mean_q;
						out_frac_q  <= frac_q;
						out_max_q   <= rmax_q;
						out_sum_q   <= rsum_q;
						out_over_q  <= rover_q;
						out_mis_q   <= mis_q;
						state_q     <= ST_ACCUM;
					end
				end
				default: state_q <= ST_ACCUM;
			endcase
		end
	end

	assign res.valid            = out_valid_q;
	assign res.mean_diff_fx     = out_mean_q;
	assign res.fraction_over_fx = out_frac_q;
	assign res.max_diff         = out_max_q;
	assign res.diff_total       = out_sum_q;
	assign res.pixels_over      = out_over_q;
	assign res.size_mismatch    = out_mis_q;

endmodule

/* rtl/rids_lane.sv */
// One channel lane: registered absolute difference of two 8-bit samples.
// Depends on rids_pkg.
`timescale 1ns / 1ps

module rids_lane import rids_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [PIX_W-1:0] a,
	input  logic [PIX_W-1:0] b,
	output logic [PIX_W-1:0] diff_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= (a > b) ? (a - b) : (b - a);
		end
	end

endmodule

/* rtl/rids_merge.sv */
// Merges lane differences and keeps the running sum, max, over count and pixel count.
// Depends on rids_pkg. Totals out include the beat currently in stage 1.
`timescale 1ns / 1ps

module rids_merge import rids_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  logic                    last_s1,
	input  logic [PIX_W-1:0]        diff_s1 [CHANNELS],
	input  logic signed [THR_W-1:0] thr,
	output acc_t                    total
);

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  over_q;
	logic [PIX_W-1:0]  max_q;
	logic [CNT_W-1:0]  n_q;
	logic [PSUM_W-1:0] psum;
	logic [PIX_W-1:0]  worst;
	logic [SUM_W:0]    sum_ext;
	logic              over_hit;

	always_comb begin
		psum  = '0;
		worst = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			psum = psum + PSUM_W'(diff_s1[c]);
			if (diff_s1[c] > worst) begin
				worst = diff_s1[c];
			end
		end
	end

	// worst is 0..255, threshold -256..255: compare as 10-bit signed
	assign over_hit = $signed({2'b00, worst}) > $signed({thr[THR_W-1], thr});
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(psum);

	always_comb begin
		total.sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		total.over = (over_hit && (over_q != '1)) ? over_q + 1'b1 : over_q;
		total.max  = (worst > max_q) ? worst : max_q;
		total.n    = (n_q != '1) ? n_q + 1'b1 : n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			over_q <= '0;
			max_q  <= '0;
			n_q    <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q  <= '0;
				over_q <= '0;
				max_q  <= '0;
				n_q    <= '0;
			end else begin
				sum_q  <= total.sum;
				over_q <= total.over;
				max_q  <= total.max;
				n_q    <= total.n;
			end
		end
	end

endmodule

/* rtl/rids_div.sv */
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// Depends on rids_pkg. Quotient is valid while done is high.
`timescale 1ns / 1ps

module rids_div import rids_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    trial;
	logic              ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

/* rtl/rids_checker.sv */
// Port-level checks on the result channel of the statistics block, plus its bind.
// Depends on rids_pkg and rgb_image_difference_stats_top_macros.svh.
`timescale 1ns / 1ps
`include "rgb_image_difference_stats_top_macros.svh"

module rids_checker import rids_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [MEAN_W-1:0] mean_diff_fx,
	input logic [FRAC_W-1:0] fraction_over_fx,
	input logic [PIX_W-1:0]  max_diff,
	input logic [SUM_W-1:0]  diff_total,
	input logic [CNT_W-1:0]  pixels_over,
	input logic              size_mismatch
);

	`RIDS_ASSERT_NEXT(a_res_valid_hold, res_valid && !res_ready, res_valid, "result beat dropped while stalled")

	`RIDS_ASSERT_NEXT(a_res_data_hold, res_valid && !res_ready, $stable(mean_diff_fx) && $stable(fraction_over_fx) && $stable(diff_total) && $stable(pixels_over), "result payload changed while stalled")

	`RIDS_ASSERT_NOW(a_mismatch_fixed, res_valid && size_mismatch, mean_diff_fx == MEAN_CAP && fraction_over_fx == FRAC_CAP && max_diff == MAX_CAP && diff_total == '0 && pixels_over == '0, "size mismatch result not fixed")

	`RIDS_ASSERT_NOW(a_caps, res_valid, mean_diff_fx <= MEAN_CAP && fraction_over_fx <= FRAC_CAP, "mean or fraction beyond clamp")

	`RIDS_ASSERT_NOW(a_no_over_no_frac, res_valid && !size_mismatch && pixels_over == '0, fraction_over_fx == '0, "fraction nonzero with no pixels over")

endmodule

bind rgb_image_difference_stats_top rids_checker u_rids_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.mean_diff_fx     (res.mean_diff_fx),
	.fraction_over_fx (res.fraction_over_fx),
	.max_diff         (res.max_diff),
	.diff_total       (res.diff_total),
	.pixels_over      (res.pixels_over),
	.size_mismatch    (res.size_mismatch)
);

/* sim/rgb_image_difference_stats_top_test.sv */
// Self-checking testbench for rgb_image_difference_stats_top: streams pixel pairs,
// predicts the per-image statistics and compares every result beat field by field.
// Depends on rids_pkg, rids_if and the top level RTL.
`timescale 1ns / 1ps

module rgb_image_difference_stats_top_test;
	import rids_pkg::*;

	localparam int RANDOM_PIXELS = 1650;
	localparam int SETTLE_CYCLES = 120;     // divider runs twice (mean, then fraction)
	localparam int DRAIN_LIMIT   = 20000;
	localparam int LONG_HOLD     = 1500;

	typedef struct packed {
		logic [PIX_W-1:0] a_red;
		logic [PIX_W-1:0] a_green;
		logic [PIX_W-1:0] a_blue;
		logic [PIX_W-1:0] b_red;
		logic [PIX_W-1:0] b_green;
		logic [PIX_W-1:0] b_blue;
		logic             last_pixel;
	} pix_beat_t;

	typedef struct {
		logic [MEAN_W-1:0] mean_diff_fx;
		logic [FRAC_W-1:0] fraction_over_fx;
		logic [PIX_W-1:0]  max_diff;
		logic [SUM_W-1:0]  diff_total;
		logic [CNT_W-1:0]  pixels_over;
		logic              size_mismatch;
	} stats_t;

	typedef enum {STYLE_RANDOM, STYLE_NEAR, STYLE_EXTREME, STYLE_SAME} pix_style_t;
	typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} rdy_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pix_beat_t beat_drv = '0;
	logic beat_valid = 1'b0;
	logic res_rdy = 1'b0;

	rids_pix_if pix_ch ();
	rids_res_if res_ch ();

	assign pix_ch.valid      = beat_valid;
	assign pix_ch.a_red      = beat_drv.a_red;
	assign pix_ch.a_green    = beat_drv.a_green;
	assign pix_ch.a_blue     = beat_drv.a_blue;
	assign pix_ch.b_red      = beat_drv.b_red;
	assign pix_ch.b_green    = beat_drv.b_green;
	assign pix_ch.b_blue     = beat_drv.b_blue;
	assign pix_ch.last_pixel = beat_drv.last_pixel;
	assign res_ch.ready      = res_rdy;

	rgb_image_difference_stats_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// settings mirror
	logic [DIM_W-1:0] width_a_m = '0, height_a_m = '0, width_b_m = '0, height_b_m = '0;
	logic signed [THR_W-1:0] threshold_m = '0;

	// running image statistics
	logic [SUM_W-1:0] acc_sum = '0;
	logic [CNT_W-1:0] acc_over = '0;
	logic [CNT_W-1:0] acc_pixels = '0;
	logic [PIX_W-1:0] acc_max = '0;

	pix_beat_t pending_pixels[$];
	stats_t expected_stats[$];

	int mismatches = 0;
	int beats_in = 0;
	int results_checked = 0;
	int mismatch_images = 0;
	int empty_images = 0;
	int settings_used = 0;
	int stall_run = 0;
	int longest_stall = 0;
	int hold_requests = 0;
	int holds_done = 0;

	task automatic note_mismatch(input string msg);
		$display("%0t ns MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint unsigned sat_add(input longint unsigned x, input longint unsigned y,
			input int w);
		longint unsigned s, cap;
		cap = (64'd1 << w) - 1;
		s = x + y;
		return (s > cap) ? cap : s;
	endfunction

	// fold one accepted pixel pair in; on the last one queue the image result
	function automatic void absorb_pixel(input pix_beat_t p);
		int av[CHANNELS], bv[CHANNELS];
		int d, worst, psum, c;
		longint unsigned num, den, q;
		stats_t r;
		av = '{int'(p.a_red), int'(p.a_green), int'(p.a_blue)};
		bv = '{int'(p.b_red), int'(p.b_green), int'(p.b_blue)};
		worst = 0;
		psum = 0;
		for (c = 0; c < CHANNELS; c++) begin
			d = (av[c] > bv[c]) ? av[c] - bv[c] : bv[c] - av[c];
			psum += d;
			if (d > worst)
				worst = d;
		end
		acc_sum = SUM_W'(sat_add(acc_sum, psum, SUM_W));
		if (worst > int'(acc_max))
			acc_max = PIX_W'(worst);
		if (worst > int'(threshold_m))
			acc_over = CNT_W'(sat_add(acc_over, 1, CNT_W));
		acc_pixels = CNT_W'(sat_add(acc_pixels, 1, CNT_W));
		if (!p.last_pixel)
			return;

		if (width_a_m != width_b_m || height_a_m != height_b_m) begin
			r = '{MEAN_CAP, FRAC_CAP, MAX_CAP, '0, '0, 1'b1};
			mismatch_images++;
		end else if (width_a_m == 0 || height_a_m == 0) begin
			r = '{'0, '0, '0, '0, '0, 1'b0};
			empty_images++;
		end else begin
			// round to nearest, ties up
			num = longint'(acc_sum) << MEAN_SHIFT;
			den = longint'(acc_pixels) * CHANNELS;
			q = (2 * num + den) / (2 * den);
			r.mean_diff_fx = (q > MEAN_CAP) ? MEAN_CAP : MEAN_W'(q);
			num = longint'(acc_over) << FRAC_SHIFT;
			den = longint'(acc_pixels);
			q = (2 * num + den) / (2 * den);
			r.fraction_over_fx = (q > FRAC_CAP) ? FRAC_CAP : FRAC_W'(q);
			r.max_diff = acc_max;
			r.diff_total = acc_sum;
			r.pixels_over = acc_over;
			r.size_mismatch = 1'b0;
		end
		expected_stats.push_back(r);
		acc_sum = '0;
		acc_over = '0;
		acc_pixels = '0;
		acc_max = '0;
	endfunction

	task automatic check_stats();
		stats_t want;
		if (expected_stats.size() == 0) begin
			note_mismatch("result beat with no image pending");
			return;
		end
		want = expected_stats.pop_front();
		results_checked++;
		if (res_ch.mean_diff_fx !== want.mean_diff_fx)
			note_mismatch($sformatf("result %0d mean_diff_fx got %0d want %0d", results_checked,
				res_ch.mean_diff_fx, want.mean_diff_fx));
		if (res_ch.fraction_over_fx !== want.fraction_over_fx)
			note_mismatch($sformatf("result %0d fraction_over_fx got %0d want %0d",
				results_checked, res_ch.fraction_over_fx, want.fraction_over_fx));
		if (res_ch.max_diff !== want.max_diff)
			note_mismatch($sformatf("result %0d max_diff got %0d want %0d", results_checked,
				res_ch.max_diff, want.max_diff));
		if (res_ch.diff_total !== want.diff_total)
			note_mismatch($sformatf("result %0d diff_total got %0d want %0d", results_checked,
				res_ch.diff_total, want.diff_total));
		if (res_ch.pixels_over !== want.pixels_over)
			note_mismatch($sformatf("result %0d pixels_over got %0d want %0d", results_checked,
				res_ch.pixels_over, want.pixels_over));
		if (res_ch.size_mismatch !== want.size_mismatch)
			note_mismatch($sformatf("result %0d size_mismatch got %0d want %0d", results_checked,
				res_ch.size_mismatch, want.size_mismatch));
	endtask

	// monitor: result checked before the pixel of the same edge is folded in
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				check_stats();
			if (pix_ch.valid && pix_ch.ready) begin
				beats_in++;
				absorb_pixel('{pix_ch.a_red, pix_ch.a_green, pix_ch.a_blue, pix_ch.b_red,
					pix_ch.b_green, pix_ch.b_blue, pix_ch.last_pixel});
			end
			if (pix_ch.valid && !pix_ch.ready)
				stall_run++;
			else
				stall_run = 0;
			if (stall_run > longest_stall)
				longest_stall = stall_run;
		end
	end

	// pixel driver: bursts of beats separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		pix_beat_t nxt_beat;
		logic nxt_valid;
		nxt_beat = beat_drv;
		nxt_valid = beat_valid;
		if (arst_n && (!beat_valid || pix_ch.ready)) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_pixels.size() > 0) begin
				nxt_beat = pending_pixels.pop_front();
				nxt_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		beat_drv <= nxt_beat;
		beat_valid <= nxt_valid;
	end

	// result receiver: own stall pattern plus long hold-offs on request
	rdy_pattern_t rdy_pattern = RDY_ALWAYS;
	int pattern_left = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		logic nxt;
		nxt = 1'b1;
		if (!arst_n) begin
			nxt = 1'b0;
		end else if (holds_done != hold_requests) begin
			holds_done++;
			hold_left = LONG_HOLD;
			nxt = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			nxt = 1'b0;
		end else begin
			if (pattern_left == 0) begin
				rdy_pattern = rdy_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(20, 300);
			end else begin
				pattern_left--;
			end
			case (rdy_pattern)
				RDY_ALWAYS: nxt = 1'b1;
				RDY_HALF:   nxt = 1'($urandom_range(0, 1));
				RDY_SPARSE: nxt = ($urandom_range(0, 7) == 0);
				default:    nxt = ($urandom_range(0, 3) != 0);
			endcase
		end
		res_rdy <= nxt;
	end

	task automatic push_pixel(input int ar, input int ag, input int ab, input int br,
			input int bg, input int bb, input bit last);
		pending_pixels.push_back('{PIX_W'(ar), PIX_W'(ag), PIX_W'(ab), PIX_W'(br), PIX_W'(bg),
			PIX_W'(bb), last});
	endtask

	task automatic queue_image(input int n, input pix_style_t style);
		pix_beat_t p;
		int k, c, t;
		logic [PIX_W-1:0] av[CHANNELS], bv[CHANNELS];
		for (k = 0; k < n; k++) begin
			for (c = 0; c < CHANNELS; c++) begin
				av[c] = PIX_W'($urandom_range(0, 255));
				case (style)
					STYLE_NEAR: begin
						t = int'(av[c]) + int'($urandom_range(0, 6)) - 3;
						bv[c] = (t < 0) ? '0 : (t > 255) ? '1 : PIX_W'(t);
					end
					STYLE_EXTREME: begin
						av[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						bv[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					STYLE_SAME: bv[c] = av[c];
					default:    bv[c] = PIX_W'($urandom_range(0, 255));
				endcase
			end
			p = '{av[0], av[1], av[2], bv[0], bv[1], bv[2], k == n - 1};
			pending_pixels.push_back(p);
		end
	endtask

	// wait until every queued pixel is in and every result is out
	task automatic drain_block();
		int guard;
		guard = 0;
		while ((pending_pixels.size() != 0 || beat_valid || expected_stats.size() != 0)
				&& guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (expected_stats.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_stats.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
	endtask

	task automatic load_settings(input int wa, input int ha, input int wb, input int hb,
			input int thr);
		drain_block();
		write_reg(REG_WIDTH_A, wa);
		write_reg(REG_HEIGHT_A, ha);
		write_reg(REG_WIDTH_B, wb);
		write_reg(REG_HEIGHT_B, hb);
		write_reg(REG_THRESHOLD, thr);
		@(posedge clk);
		cfg_we <= 1'b0;
		width_a_m = DIM_W'(wa);
		height_a_m = DIM_W'(ha);
		width_b_m = DIM_W'(wb);
		height_b_m = DIM_W'(hb);
		threshold_m = THR_W'(thr);
		settings_used++;
	endtask

	initial begin
		int random_pixels, phase, kind, n_images, i, n, area;
		int wa, ha, wb, hb, thr;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: both sizes zero, so an empty image
		push_pixel(255, 0, 255, 0, 255, 0, 1);

		load_settings(2, 2, 2, 2, 0);
		push_pixel(255, 255, 255, 0, 0, 0, 0);
		push_pixel(0, 0, 0, 255, 255, 255, 0);
		push_pixel(7, 7, 7, 7, 7, 7, 0);
		push_pixel(10, 200, 30, 20, 100, 30, 1);
		push_pixel(1, 0, 0, 0, 0, 0, 1);   // single-pixel image, just over zero

		load_settings(1, 1, 1, 1, -1);     // every pixel over, even identical ones
		push_pixel(128, 64, 32, 128, 64, 32, 0);
		push_pixel(0, 0, 0, 0, 0, 0, 1);

		load_settings(4096, 4096, 4096, 4096, 255);   // worst 255 is not over 255
		push_pixel(255, 0, 255, 0, 255, 0, 0);
		push_pixel(0, 255, 0, 255, 0, 255, 0);
		push_pixel(255, 255, 255, 0, 0, 0, 1);

		load_settings(4096, 1, 4095, 1, 100);   // width differs
		push_pixel(3, 4, 5, 6, 7, 8, 0);
		push_pixel(9, 9, 9, 1, 1, 1, 1);

		load_settings(3, 5, 3, 6, 0);           // height differs
		push_pixel(200, 100, 50, 0, 0, 0, 1);

		load_settings(0, 4096, 0, 4096, 0);     // zero width, data ignored
		push_pixel(255, 255, 255, 0, 0, 0, 0);
		push_pixel(1, 2, 3, 4, 5, 6, 1);

		load_settings(4096, 0, 4096, 0, 0);     // zero height
		push_pixel(90, 80, 70, 10, 20, 30, 1);

		random_pixels = 0;
		phase = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			kind = $urandom_range(0, 11);
			case ($urandom_range(0, 4))
				0:       thr = -1;
				1:       thr = 255;
				2:       thr = 0;
				default: thr = $urandom_range(0, 255);
			endcase
			case (kind)
				0: begin
					wa = $urandom_range(0, 4096);
					ha = $urandom_range(0, 4096);
					wb = wa;
					hb = ha;
					if ($urandom_range(0, 1))
						wb = (wa == 0) ? 1 : wa - 1;
					else
						hb = (ha == 4096) ? 0 : ha + 1;
				end
				1: begin
					wa = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4096);
					ha = (wa == 0) ? $urandom_range(0, 4096) : 0;
					wb = wa;
					hb = ha;
				end
				2: begin
					wa = 4096;
					ha = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 4096);
					wb = wa;
					hb = ha;
				end
				default: begin
					wa = $urandom_range(1, 8);
					ha = $urandom_range(1, 8);
					wb = wa;
					hb = ha;
				end
			endcase
			load_settings(wa, ha, wb, hb, thr);
			// once: receiver holds off while several images stream in
			if (phase == 3)
				hold_requests++;
			// three or more images in the hold phase so one waits behind the held result and stalls input
			n_images = (kind <= 1 && phase != 3) ? $urandom_range(2, 4)
				: $urandom_range(3, 12);
			area = wa * ha;
			for (i = 0; i < n_images; i++) begin
				if (area > 0 && area <= 64 && $urandom_range(0, 4) != 0)
					n = area;
				else if ($urandom_range(0, 39) == 0)
					n = $urandom_range(100, 400);
				else
					n = $urandom_range(1, 20);
				queue_image(n, pix_style_t'($urandom_range(0, 3)));
				random_pixels += n;
			end
			phase++;
		end

		drain_block();
		$display("summary: %0d pixel beats, %0d images checked (%0d size mismatch, %0d empty)",
			beats_in, results_checked, mismatch_images, empty_images);
		$display("summary: %0d register settings, longest input stall %0d cycles, %0d errors",
			settings_used, longest_stall, mismatches);
		if (mismatches == 0)
			$display("rgb_image_difference_stats_top verification clean");
		else
			$display("rgb_image_difference_stats_top verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout after %0t ns", $time);
		$display("rgb_image_difference_stats_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rids_pkg.sv
rtl/rids_if.sv
rtl/rids_lane.sv
rtl/rids_merge.sv
rtl/rids_div.sv
rtl/rgb_image_difference_stats_top.sv
rtl/rids_checker.sv
sim/rgb_image_difference_stats_top_test.sv
